[hw/rtl/rsw_pkg.sv]
// Shared types and constants of the reliable send window.
// No dependencies; every other file of the block but rsw_ram imports this package.
package rsw_pkg;

    // Operation codes of an input item
    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic [2:0] KIND_STORED    = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_ACKED     = 3'd2;
    localparam logic [2:0] KIND_UNMATCHED = 3'd3;
    localparam logic [2:0] KIND_RETX      = 3'd4;
    localparam logic [2:0] KIND_IDLE      = 3'd5;

    // Configuration register indexes
    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_MAX  = 1'b1;

    localparam int BASE_W = 16;
    localparam int MAX_W  = 20;
    localparam int CFG_W  = 20;

    // Backoff may exceed the cap once: below 2*max, or at the base if that is larger
    localparam int BACKOFF_W = MAX_W + 1;

    // A tick reports at most this many slots
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    // One slot of the window as held in memory
    typedef struct packed {
        logic [31:0] id;
        logic [15:0] handle;
        logic [15:0] len;
        logic [31:0] deadline;
    } slot_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] id;
        logic [15:0] handle;
        logic [15:0] len;
        logic        last;
    } result_t;

endpackage

[hw/rtl/rsw_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data holds while re is low
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/rsw_out.sv]
// Result output register of the reliable send window.
// Depends on rsw_pkg for the result type.
module rsw_out (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  rsw_pkg::result_t data,
    output logic            out_free,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_kind,
    output logic [31:0]     m_out_id,
    output logic [15:0]     m_out_handle,
    output logic [15:0]     m_out_len,
    output logic            m_last
);
    import rsw_pkg::*;

    logic    m_valid_reg;
    logic    m_valid_next;
    result_t data_reg;

    // Free when empty or when the held result transfers now
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = data_reg.kind;
    assign m_out_id     = data_reg.id;
    assign m_out_handle = data_reg.handle;
    assign m_out_len    = data_reg.len;
    assign m_last       = data_reg.last;

endmodule

[hw/rtl/rsw_engine.sv]
// Sequencer of the reliable send window: slot valid bits, store, ack search
// and tick scan over the slot memory. Depends on rsw_pkg.
module rsw_engine #(
    parameter int WINDOW_SLOTS = 8,
    localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [31:0]                  s_msg_id,
    input  logic [15:0]                  s_buf_handle,
    input  logic [15:0]                  s_msg_len,
    input  logic [31:0]                  s_now_ms,
    // configuration
    input  logic [rsw_pkg::BASE_W-1:0]   base_interval,
    input  logic [rsw_pkg::MAX_W-1:0]    max_interval,
    // slot memory
    output logic                         mem_we,
    output logic [IDX_W-1:0]             mem_waddr,
    output rsw_pkg::slot_t               mem_wdata,
    output logic                         mem_re,
    output logic [IDX_W-1:0]             mem_raddr,
    input  rsw_pkg::slot_t               mem_rdata,
    // output register
    output logic                         out_load,
    output rsw_pkg::result_t             out_data,
    input  logic                         out_free
);
    import rsw_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]              state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [1:0]              op_reg, op_next;
    logic [31:0]             id_reg, id_next;
    logic [31:0]             now_reg, now_next;
    logic [BACKOFF_W-1:0]    backoff_reg, backoff_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    pend_valid_reg, pend_valid_next;
    result_t                 pend_reg, pend_next;
    logic [WINDOW_SLOTS-1:0] valid_reg, valid_next;

    logic             accept;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
    logic             slot_ok;
    logic             hit;
    logic             due;
    logic             last_slot;
    logic [IDX_W-1:0] idx_inc;
    slot_t            new_row;
    slot_t            rearm_row;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IDX_W'(i);
            end
        end
    end

    // Per-slot tests on the row just read
    assign slot_ok   = valid_reg[idx_reg];
    assign hit       = slot_ok && (mem_rdata.id == id_reg);
    assign due       = slot_ok && (now_reg >= mem_rdata.deadline);
    assign last_slot = (idx_reg == IDX_W'(WINDOW_SLOTS - 1));
    assign idx_inc   = idx_reg + IDX_W'(1);

    always_comb begin
        new_row.id       = s_msg_id;
        new_row.handle   = s_buf_handle;
        new_row.len      = s_msg_len;
        new_row.deadline = s_now_ms + {{(32 - BASE_W){1'b0}}, base_interval};
        rearm_row          = mem_rdata;
        rearm_row.deadline = now_reg + {{(32 - BACKOFF_W){1'b0}}, backoff_reg};
    end

    // Next state and memory control
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        now_next        = now_reg;
        backoff_next    = backoff_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        mem_waddr       = idx_reg;
        mem_wdata       = rearm_row;
        mem_re          = 1'b0;
        mem_raddr       = idx_inc;
        out_load        = 1'b0;
        out_data        = pend_reg;
        out_data.last   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next         = s_operation;
                    id_next         = s_msg_id;
                    now_next        = s_now_ms;
                    idx_next        = '0;
                    cnt_next        = '0;
                    backoff_next    = BACKOFF_W'(base_interval);
                    pend_valid_next = 1'b0;
                    case (s_operation)
                        OP_STORE: begin
                            pend_valid_next = 1'b1;
                            state_next      = ST_FINISH;
                            if (free_found) begin
                                valid_next[free_idx] = 1'b1;
                                mem_we           = 1'b1;
                                mem_waddr        = free_idx;
                                mem_wdata        = new_row;
                                pend_next.kind   = KIND_STORED;
                                pend_next.id     = s_msg_id;
                                pend_next.handle = s_buf_handle;
                                pend_next.len    = s_msg_len;
                            end else begin
                                pend_next.kind   = KIND_FULL;
                                pend_next.id     = s_msg_id;
                                pend_next.handle = '0;
                                pend_next.len    = '0;
                            end
                            pend_next.last = 1'b0;
                        end
                        OP_ACK, OP_TICK: begin
                            mem_re     = 1'b1;
                            mem_raddr  = '0;
                            state_next = ST_SCAN;
                        end
                        default: begin
                            // unknown operation: no effect, no result
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (op_reg == OP_ACK) begin
                    if (hit) begin
                        valid_next[idx_reg] = 1'b0;
                        pend_valid_next  = 1'b1;
                        pend_next.kind   = KIND_ACKED;
                        pend_next.id     = id_reg;
                        pend_next.handle = mem_rdata.handle;
                        pend_next.len    = mem_rdata.len;
                        pend_next.last   = 1'b0;
                        state_next       = ST_FINISH;
                    end else if (last_slot) begin
                        pend_valid_next  = 1'b1;
                        pend_next.kind   = KIND_UNMATCHED;
                        pend_next.id     = id_reg;
                        pend_next.handle = '0;
                        pend_next.len    = '0;
                        pend_next.last   = 1'b0;
                        state_next       = ST_FINISH;
                    end else begin
                        mem_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end else if (!(due && pend_valid_reg && !out_free)) begin
                    // tick: the result of a due slot is held back as pending so that the
                    // final one can be marked last
                    if (due) begin
                        mem_we           = 1'b1;
                        cnt_next         = cnt_reg + CNT_W'(1);
                        backoff_next     = (backoff_reg < {1'b0, max_interval}) ?
                                           {backoff_reg[BACKOFF_W-2:0], 1'b0} :
                                           {1'b0, max_interval};
                        pend_valid_next  = 1'b1;
                        pend_next.kind   = KIND_RETX;
                        pend_next.id     = mem_rdata.id;
                        pend_next.handle = mem_rdata.handle;
                        pend_next.len    = mem_rdata.len;
                        pend_next.last   = 1'b0;
                        out_load         = pend_valid_reg;
                    end
                    if (last_slot || (due && cnt_reg == CNT_W'(MAX_RESULTS - 1))) begin
                        state_next = ST_FINISH;
                    end else begin
                        mem_re   = 1'b1;
                        idx_next = idx_inc;
                    end
                end
            end

            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (!pend_valid_reg) begin
                        out_data.kind   = KIND_IDLE;
                        out_data.id     = '0;
                        out_data.handle = '0;
                        out_data.len    = '0;
                    end
                    out_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            valid_reg      <= '0;
            cnt_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            valid_reg      <= valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Item context and pending result
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        op_reg      <= op_next;
        id_reg      <= id_next;
        now_reg     <= now_next;
        backoff_reg <= backoff_next;
        pend_reg    <= pend_next;
    end

    // A store always leaves a pending result for the finish step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_operation == OP_STORE) |=> (state_reg == ST_FINISH && pend_valid_reg))
        else $error("store did not leave a pending result");

    // A tick never reports more slots than the result limit
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("tick result count over limit");

    // Memory rewrites during a scan belong to a tick
    assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && state_reg == ST_SCAN) |-> (op_reg == OP_TICK && due))
        else $error("slot rewritten outside a tick");

    // Occupancy moves by at most one slot per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(valid_reg) |->
            ($countones(valid_reg) == $countones($past(valid_reg)) + 1 ||
             $countones(valid_reg) + 1 == $countones($past(valid_reg))))
        else $error("more than one slot changed occupancy");

    // Only the finish step marks a result last
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_data.last) |-> (state_reg == ST_FINISH))
        else $error("last marked outside finish");

endmodule

[hw/rtl/reliable_send_window_unit.sv]
// Reliable send window: keeps up to WINDOW_SLOTS unacknowledged messages in a
// one-port-read, one-port-write slot memory with per-slot valid flip-flops.
// A store is accepted, then its result is given in the finish step. An ack
// searches the slots in order, one memory read per cycle, until a match or
// the last slot. A tick scans every slot the same way, or stops early when
// eight slots are found due; its scan stalls while a due slot's result waits
// on m_ready. The single memory read port limits the scans to one slot per
// cycle. Results leave through an output register, so the next item can be
// taken while the last result of an item is still waiting. No clearing pass
// is needed after reset. Depends on rsw_pkg, rsw_ram, rsw_engine and rsw_out.
module reliable_send_window_unit #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write port
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [rsw_pkg::CFG_W-1:0] cfg_wr_data,
    // input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_operation,
    input  logic [31:0]               s_msg_id,
    input  logic [15:0]               s_buf_handle,
    input  logic [15:0]               s_msg_len,
    input  logic [31:0]               s_now_ms,
    // result channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [2:0]                m_kind,
    output logic [31:0]               m_out_id,
    output logic [15:0]               m_out_handle,
    output logic [15:0]               m_out_len,
    output logic                      m_last
);
    import rsw_pkg::*;

    localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;

    logic [BASE_W-1:0] base_reg;
    logic [MAX_W-1:0]  max_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    slot_t            mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    slot_t            mem_rdata;
    logic             out_load;
    result_t          out_data;
    logic             out_free;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= BASE_W'(2000);
            max_reg  <= MAX_W'(16000);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_BASE: base_reg <= cfg_wr_data[BASE_W-1:0];
                CFG_MAX:  max_reg  <= cfg_wr_data[MAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rsw_ram #(
        .WIDTH($bits(slot_t)),
        .DEPTH(WINDOW_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rsw_engine #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) u_engine (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_msg_id      (s_msg_id),
        .s_buf_handle  (s_buf_handle),
        .s_msg_len     (s_msg_len),
        .s_now_ms      (s_now_ms),
        .base_interval (base_reg),
        .max_interval  (max_reg),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_re        (mem_re),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata),
        .out_load      (out_load),
        .out_data      (out_data),
        .out_free      (out_free)
    );

    rsw_out u_out (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (out_load),
        .data         (out_data),
        .out_free     (out_free),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_out_id     (m_out_id),
        .m_out_handle (m_out_handle),
        .m_out_len    (m_out_len),
        .m_last       (m_last)
    );

endmodule

[test/rsw_checker.sv]
// Scoreboard for the reliable send window: watches the config port and both channels,
// predicts every result from its own copy of the slots and compares field by field.
// Depends on rsw_pkg for the operation codes, result kinds and the result layout.
module rsw_checker #(
    parameter int WINDOW_SLOTS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_index,
    input  logic [rsw_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    input  logic                      s_ready,
    input  logic [1:0]                s_operation,
    input  logic [31:0]               s_msg_id,
    input  logic [15:0]               s_buf_handle,
    input  logic [15:0]               s_msg_len,
    input  logic [31:0]               s_now_ms,
    input  logic                      m_valid,
    input  logic                      m_ready,
    input  logic [2:0]                m_kind,
    input  logic [31:0]               m_out_id,
    input  logic [15:0]               m_out_handle,
    input  logic [15:0]               m_out_len,
    input  logic                      m_last,
    output int                        fail_count,
    output int                        pending,
    output int                        results_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import rsw_pkg::*;

    localparam logic [15:0] RESET_BASE_MS = 16'd2000;
    localparam logic [19:0] RESET_MAX_MS  = 20'd16000;

    // mirrored window and interval registers
    logic        slot_used [WINDOW_SLOTS];
    logic [31:0] slot_msg_id [WINDOW_SLOTS];
    logic [15:0] slot_buf [WINDOW_SLOTS];
    logic [15:0] slot_bytes [WINDOW_SLOTS];
    logic [31:0] slot_due [WINDOW_SLOTS];
    logic [15:0] base_ms;
    logic [19:0] max_ms;

    result_t expected_results[$];

    function automatic result_t make_result(logic [2:0] kind, logic [31:0] id,
                                            logic [15:0] handle, logic [15:0] len,
                                            logic last);
        result_t r;
        r.kind   = kind;
        r.id     = id;
        r.handle = handle;
        r.len    = len;
        r.last   = last;
        return r;
    endfunction

    // Apply one accepted input item to the window and queue what it must produce
    task automatic predict_window(input logic [1:0] op, input logic [31:0] id,
                                  input logic [15:0] handle, input logic [15:0] len,
                                  input logic [31:0] now);
        int          slot;
        int          due_total;
        int          emitted;
        logic [31:0] backoff;
        slot = -1;
        case (op)
            OP_STORE: begin
                for (int i = 0; i < WINDOW_SLOTS; i++) begin
                    if (slot < 0 && !slot_used[i]) slot = i;
                end
                if (slot < 0) begin
                    expected_results.push_back(make_result(KIND_FULL, id, 16'd0, 16'd0, 1'b1));
                end else begin
                    slot_used[slot]   = 1'b1;
                    slot_msg_id[slot] = id;
                    slot_buf[slot]    = handle;
                    slot_bytes[slot]  = len;
                    slot_due[slot]    = now + {16'd0, base_ms};
                    expected_results.push_back(make_result(KIND_STORED, id, handle, len, 1'b1));
                end
            end
            OP_ACK: begin
                for (int i = 0; i < WINDOW_SLOTS; i++) begin
                    if (slot < 0 && slot_used[i] && slot_msg_id[i] == id) slot = i;
                end
                if (slot < 0) begin
                    expected_results.push_back(
                        make_result(KIND_UNMATCHED, id, 16'd0, 16'd0, 1'b1));
                end else begin
                    slot_used[slot] = 1'b0;
                    expected_results.push_back(
                        make_result(KIND_ACKED, id, slot_buf[slot], slot_bytes[slot], 1'b1));
                end
            end
            OP_TICK: begin
                // count first so the final retransmit can carry last
                due_total = 0;
                for (int i = 0; i < WINDOW_SLOTS; i++) begin
                    if (slot_used[i] && now >= slot_due[i]) due_total++;
                end
                if (due_total > MAX_RESULTS) due_total = MAX_RESULTS;
                if (due_total == 0) begin
                    expected_results.push_back(make_result(KIND_IDLE, 32'd0, 16'd0, 16'd0, 1'b1));
                end
                emitted = 0;
                backoff = {16'd0, base_ms};
                for (int i = 0; i < WINDOW_SLOTS; i++) begin
                    if (emitted < due_total && slot_used[i] && now >= slot_due[i]) begin
                        expected_results.push_back(make_result(KIND_RETX, slot_msg_id[i],
                            slot_buf[i], slot_bytes[i], emitted == due_total - 1));
                        emitted++;
                        slot_due[i] = now + backoff;
                        // doubles below the cap, may overshoot once, then clamps
                        backoff = (backoff < {12'd0, max_ms}) ? (backoff << 1) : {12'd0, max_ms};
                    end
                end
            end
            default: begin
                // unknown operation: no effect
            end
        endcase
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // Monitor: results first (always from an earlier item), then the new item
    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            for (int i = 0; i < WINDOW_SLOTS; i++) slot_used[i] = 1'b0;
            base_ms = RESET_BASE_MS;
            max_ms  = RESET_MAX_MS;
            expected_results.delete();
            fail_count      = 0;
            pending         = 0;
            results_checked = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_BASE: base_ms = cfg_wr_data[BASE_W-1:0];
                    CFG_MAX:  max_ms  = cfg_wr_data[MAX_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_checked++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: unexpected result, expected none, got kind %0d id %0h",
                             $time, m_kind, m_out_id);
                end else begin
                    want = expected_results.pop_front();
                    check_field("kind", want.kind, m_kind);
                    check_field("out_id", want.id, m_out_id);
                    check_field("out_handle", want.handle, m_out_handle);
                    check_field("out_len", want.len, m_out_len);
                    check_field("last", want.last, m_last);
                end
            end
            if (s_valid && s_ready) begin
                predict_window(s_operation, s_msg_id, s_buf_handle, s_msg_len, s_now_ms);
            end
            pending = expected_results.size();
        end
    end

endmodule

[test/tb.sv]
// Top of the reliable send window testbench: clock, reset, stimulus and verdict.
// Depends on rsw_pkg, the reliable_send_window_unit RTL and rsw_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rsw_pkg::*;

    localparam int          WINDOW_SLOTS    = 8;
    localparam logic [1:0]  OP_UNUSED       = 2'd3;
    localparam int          NUM_PHASES      = 6;
    localparam int          ITEMS_PER_PHASE = 75;
    localparam int          LONG_STALL      = 200;
    localparam int          SETTLE_CYCLES   = 4 * (WINDOW_SLOTS + 2);
    localparam int          CYCLE_LIMIT     = 300000;

    logic              aclk;
    logic              aresetn;
    logic              cfg_wr_en;
    logic              cfg_index;
    logic [CFG_W-1:0]  cfg_wr_data;
    logic              s_valid;
    logic              s_ready;
    logic [1:0]        s_operation;
    logic [31:0]       s_msg_id;
    logic [15:0]       s_buf_handle;
    logic [15:0]       s_msg_len;
    logic [31:0]       s_now_ms;
    logic              m_valid;
    logic              m_ready;
    logic [2:0]        m_kind;
    logic [31:0]       m_out_id;
    logic [15:0]       m_out_handle;
    logic [15:0]       m_out_len;
    logic              m_last;

    int fail_count;
    int pending;
    int results_checked;

    // stimulus shaping state
    bit          calm;
    int          stall_requests;
    int          ops_sent [4];
    int          cycle_count;
    logic [31:0] now_clock;
    logic [15:0] cur_base;
    logic [31:0] open_ids[$];

    reliable_send_window_unit #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_msg_id    (s_msg_id),
        .s_buf_handle(s_buf_handle),
        .s_msg_len   (s_msg_len),
        .s_now_ms    (s_now_ms),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_kind      (m_kind),
        .m_out_id    (m_out_id),
        .m_out_handle(m_out_handle),
        .m_out_len   (m_out_len),
        .m_last      (m_last)
    );

    rsw_checker #(
        .WINDOW_SLOTS(WINDOW_SLOTS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_msg_id       (s_msg_id),
        .s_buf_handle   (s_buf_handle),
        .s_msg_len      (s_msg_len),
        .s_now_ms       (s_now_ms),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_out_id       (m_out_id),
        .m_out_handle   (m_out_handle),
        .m_out_len      (m_out_len),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending        (pending),
        .results_checked(results_checked)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb NOT OK");
        $finish;
    end

    // Result side: random ready bursts, one long hold-off on request
    initial begin : receiver
        int stall_served;
        stall_served = 0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (stall_requests > stall_served) begin
                stall_served++;
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge aclk);
            end
        end
    end

    // One input transfer; called at a falling edge, returns at a falling edge
    task automatic send_item(input logic [1:0] op, input logic [31:0] id,
                             input logic [15:0] handle, input logic [15:0] len,
                             input logic [31:0] now);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_operation  <= op;
        s_msg_id     <= id;
        s_buf_handle <= handle;
        s_msg_len    <= len;
        s_now_ms     <= now;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ops_sent[op]++;
        @(negedge aclk);
    endtask

    // Stop offering, let every expected result arrive, then let the block go quiet
    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic set_intervals(input logic [CFG_W-1:0] base_data,
                                 input logic [CFG_W-1:0] max_data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= CFG_BASE;
        cfg_wr_data <= base_data;
        @(negedge aclk);
        cfg_index   <= CFG_MAX;
        cfg_wr_data <= max_data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_base     = base_data[BASE_W-1:0];
    endtask

    // Mostly store/ack/tick traffic with advancing time, a little noise
    task automatic random_item();
        int          pick;
        int          idx;
        logic [31:0] id;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            if (open_ids.size() > 0 && $urandom_range(0, 7) == 0) begin
                id = open_ids[$urandom_range(0, open_ids.size() - 1)];
            end else begin
                id = $urandom();
            end
            open_ids.push_back(id);
            if (open_ids.size() > 16) void'(open_ids.pop_front());
            now_clock = now_clock + $urandom_range(0, cur_base / 4);
            send_item(OP_STORE, id, $urandom(), $urandom(), now_clock);
        end else if (pick < 70) begin
            if (open_ids.size() > 0 && $urandom_range(0, 99) < 85) begin
                idx = $urandom_range(0, open_ids.size() - 1);
                id  = open_ids[idx];
                open_ids.delete(idx);
            end else begin
                id = $urandom();
            end
            send_item(OP_ACK, id, $urandom(), $urandom(), $urandom());
        end else if (pick < 95) begin
            if ($urandom_range(0, 29) == 0) begin
                // out-of-order time stamp
                send_item(OP_TICK, $urandom(), $urandom(), $urandom(), $urandom());
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    now_clock = now_clock + $urandom_range(0, 40 * cur_base);
                end else begin
                    now_clock = now_clock + $urandom_range(0, cur_base);
                end
                send_item(OP_TICK, $urandom(), $urandom(), $urandom(), now_clock);
            end
        end else begin
            send_item(OP_UNUSED, $urandom(), $urandom(), $urandom(), $urandom());
        end
    endtask

    // Main stimulus
    initial begin : stimulus
        logic [CFG_W-1:0] base_data;
        logic [CFG_W-1:0] max_data;
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_BASE;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_operation  = OP_STORE;
        s_msg_id     = '0;
        s_buf_handle = '0;
        s_msg_len    = '0;
        s_now_ms     = '0;
        calm           = 1'b0;
        stall_requests = 0;
        for (int i = 0; i < 4; i++) ops_sent[i] = 0;
        now_clock = '0;
        cur_base  = 16'd2000;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part at the reset intervals
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'd0);           // empty window: nothing due
        send_item(OP_ACK, 32'd0, 16'd0, 16'd0, 32'd0);            // ack on empty window
        send_item(OP_UNUSED, '1, '1, '1, '1);                     // ignored
        send_item(OP_STORE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'd0);
        send_item(OP_STORE, 32'd0, 16'd0, 16'd0, 32'd0);
        send_item(OP_STORE, 32'h1234_5678, 16'h0101, 16'h0040, 32'd10);
        send_item(OP_STORE, 32'h1234_5678, 16'h0202, 16'h0080, 32'd20);  // duplicate id
        for (int k = 0; k < 4; k++) begin
            send_item(OP_STORE, 32'hA000_0000 + k, 16'h1000 + k, 16'h0100 + k, 32'd30);
        end
        send_item(OP_STORE, 32'hDEAD_BEEF, 16'h5555, 16'hAAAA, 32'd40); // window full
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'd1999);        // one short of due
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'd2000);        // deadline equal to now
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'd2030);
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'h0010_0000);   // all due, backoff hits cap
        send_item(OP_ACK, 32'h1234_5678, 16'd0, 16'd0, 32'd0);    // first duplicate freed
        send_item(OP_STORE, 32'h0BAD_F00D, 16'h7777, 16'h0001, 32'hFFFF_FC00); // deadline wraps
        send_item(OP_TICK, 32'd0, 16'd0, 16'd0, 32'hFFFF_FFFF);
        send_item(OP_ACK, 32'h1234_5678, 16'd0, 16'd0, 32'd0);    // second duplicate freed
        send_item(OP_ACK, 32'h1234_5678, 16'd0, 16'd0, 32'd0);    // now unmatched
        send_item(OP_ACK, 32'hFFFF_FFFF, 16'd0, 16'd0, 32'd0);
        send_item(OP_ACK, 32'd0, 16'd0, 16'd0, 32'd0);
        for (int k = 0; k < 4; k++) open_ids.push_back(32'hA000_0000 + k);
        open_ids.push_back(32'h0BAD_F00D);

        // Random phases, one interval setting each
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                wait_drain();
                case (ph)
                    1:       begin base_data = 20'h0_0001; max_data = 20'h0_0001; end
                    2:       begin base_data = 20'hF_FFFF; max_data = 20'hF_FFFF; end
                    3:       begin base_data = 20'h3_0064; max_data = 20'd800;    end
                    4:       begin base_data = 20'd7;      max_data = 20'd5;      end
                    default: begin
                        base_data = $urandom_range(1, 3000);
                        max_data  = $urandom_range(1, 50000);
                    end
                endcase
                set_intervals(base_data, max_data);
            end
            if (ph == 2) now_clock = 32'hFFFF_0000;   // run deadlines across the wrap
            calm = (ph == NUM_PHASES - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (ph == 1 && k == 20) stall_requests++;
                if (ph == 3 && k == 40) wait_drain();
                random_item();
            end
        end

        wait_drain();
        $display("tb: %0d items (%0d store, %0d ack, %0d tick, %0d unknown), %0d results",
                 ops_sent[0] + ops_sent[1] + ops_sent[2] + ops_sent[3],
                 ops_sent[OP_STORE], ops_sent[OP_ACK], ops_sent[OP_TICK], ops_sent[OP_UNUSED],
                 results_checked);
        $display("tb: six interval settings incl. extremes, masking and base above cap");
        if (fail_count == 0 && pending == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/rsw_pkg.sv
hw/rtl/rsw_ram.sv
hw/rtl/rsw_out.sv
hw/rtl/rsw_engine.sv
hw/rtl/reliable_send_window_unit.sv
test/rsw_checker.sv
test/tb.sv
